>>> hdl/alt_pkg.sv
`timescale 1ns / 1ps

package alt_pkg;

    localparam int MAX_TOKENS      = 8;
    localparam int MAX_TOKEN_CHARS = 1024;

    // token_count saturates at MAX_TOKENS + 1, char_count counts up to MAX_TOKEN_CHARS
    localparam int TC_W = $clog2(MAX_TOKENS + 2);
    localparam int CC_W = $clog2(MAX_TOKEN_CHARS + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_TEND = 2'd1,
        KIND_LEND = 2'd2
    } kind_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  char_value;
        logic [2:0]  token_index;
        logic [9:0]  char_position;
        logic        from_string;
        logic        overflow;
        logic        last;
    } res_t;

    // C escape letters; anything else stands for itself
    function automatic logic [7:0] escape_map(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        unique case (c)
            8'h61:   r = 8'h07;  // a
            8'h62:   r = 8'h08;  // b
            8'h66:   r = 8'h0C;  // f
            8'h6E:   r = 8'h0A;  // n
            8'h72:   r = 8'h0D;  // r
            8'h74:   r = 8'h09;  // t
            8'h76:   r = 8'h0B;  // v
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_COMMA);
    endfunction

    function automatic logic is_line_end(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_LF) || (c == CH_CR) || (c == CH_SEMI);
    endfunction

endpackage

>>> hdl/assembly_line_tokenizer.sv
`timescale 1ns / 1ps

// Streaming lexer for assembly source lines: one character per transfer in, token
// characters, token ends and line ends out, one result per transfer. A character is
// taken every cycle as long as the 4-entry result queue has room for two results;
// characters that yield two results (a token end followed by a line end) put both into
// the queue at once, and the single result port drains it one result at a time; the
// sustained rate is one character per cycle whenever the result side keeps up.
module assembly_line_tokenizer
    import alt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] line_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] char_value, [10:8] token_index,
                                   // [20:11] char_position, [21] from_string,
                                   // [22] overflow, [23] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_WORD = 3'd1,
        M_STR  = 3'd2,
        M_ESC  = 3'd3,
        M_SKIP = 3'd4,
        M_DONE = 3'd5
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic [TC_W-1:0]   tc_reg, tc_next;
    logic [CC_W-1:0]   cc_reg, cc_next;
    logic              ov_reg, ov_next;

    res_t              fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] head_reg, tail_reg;
    logic [FIFO_AW:0]  count_reg;

    res_t              r0, r1;
    logic [1:0]        n_res;
    logic              s_acc, m_acc;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = (count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign m_tvalid = (count_reg != '0);

    // one character through the scanner
    always_comb begin
        logic [7:0]      c;
        mode_t           md;
        logic [TC_W-1:0] tc;
        logic [CC_W-1:0] cc;
        logic            ov;
        logic            do_start;
        logic            do_char;
        logic [7:0]      ch_val;
        logic            fs;
        logic            do_tend;
        logic            do_lend;
        logic            live;
        res_t            rr;

        c        = s_tdata;
        md       = s_tuser ? M_IDLE : mode_reg;
        tc       = s_tuser ? '0 : tc_reg;
        cc       = s_tuser ? '0 : cc_reg;
        ov       = s_tuser ? 1'b0 : ov_reg;
        do_start = 1'b0;
        do_char  = 1'b0;
        do_tend  = 1'b0;
        do_lend  = 1'b0;
        ch_val   = c;
        fs       = 1'b0;
        mode_next = md;
        r0       = '0;
        r1       = '0;
        n_res    = 2'd0;
        rr       = '0;

        unique case (md)
            M_IDLE, M_SKIP: begin
                priority if (is_line_end(c)) begin
                    do_lend = 1'b1;
                end else if (c == CH_QUOTE) begin
                    do_start  = 1'b1;
                    mode_next = M_STR;
                end else if (is_sep(c)) begin
                    mode_next = M_IDLE;
                end else if (md == M_IDLE) begin
                    do_start  = 1'b1;
                    do_char   = 1'b1;
                    mode_next = M_WORD;
                end else begin
                    // glued after a closing quote: skipped
                    mode_next = M_SKIP;
                end
            end
            M_WORD: begin
                priority if (is_line_end(c)) begin
                    do_tend = 1'b1;
                    do_lend = 1'b1;
                end else if (is_sep(c)) begin
                    do_tend   = 1'b1;
                    mode_next = M_IDLE;
                end else begin
                    do_char = 1'b1;
                end
            end
            M_STR: begin
                fs = 1'b1;
                priority if (c == CH_NUL) begin
                    do_tend = 1'b1;
                    do_lend = 1'b1;
                end else if (c == CH_QUOTE) begin
                    do_tend   = 1'b1;
                    mode_next = M_SKIP;
                end else if (c == CH_BSL) begin
                    mode_next = M_ESC;
                end else begin
                    do_char = 1'b1;
                end
            end
            M_ESC: begin
                fs = 1'b1;
                if (c == CH_NUL) begin
                    do_tend = 1'b1;
                    do_lend = 1'b1;
                end else begin
                    do_char   = 1'b1;
                    ch_val    = escape_map(c);
                    mode_next = M_STR;
                end
            end
            default: mode_next = M_DONE;
        endcase

        if (do_start) begin
            if (tc <= TC_W'(MAX_TOKENS)) begin
                tc = tc + 1'b1;
            end
            if (tc > TC_W'(MAX_TOKENS)) begin
                ov = 1'b1;
            end
            cc = '0;
        end

        live = (tc != '0) && (tc <= TC_W'(MAX_TOKENS));

        // only one of token character and token end happens per character
        if (do_char && live) begin
            if (cc >= CC_W'(MAX_TOKEN_CHARS)) begin
                ov = 1'b1;
            end else begin
                rr.kind          = KIND_CHAR;
                rr.char_value    = ch_val;
                rr.token_index   = 3'(tc - 1'b1);
                rr.char_position = 10'(cc);
                rr.from_string   = fs;
                rr.overflow      = ov;
                r0    = rr;
                n_res = 2'd1;
                cc    = cc + 1'b1;
            end
        end else if (do_tend && live) begin
            rr.kind        = KIND_TEND;
            rr.token_index = 3'(tc - 1'b1);
            rr.from_string = fs;
            rr.overflow    = ov;
            r0    = rr;
            n_res = 2'd1;
        end

        if (do_lend) begin
            rr          = '0;
            rr.kind     = KIND_LEND;
            rr.overflow = ov;
            if (n_res == 2'd0) begin
                r0 = rr;
            end else begin
                r1 = rr;
            end
            n_res     = n_res + 2'd1;
            mode_next = M_DONE;
        end

        if (n_res == 2'd1) begin
            r0.last = 1'b1;
        end else if (n_res == 2'd2) begin
            r1.last = 1'b1;
        end

        tc_next = tc;
        cc_next = cc;
        ov_next = ov;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            tc_reg    <= '0;
            cc_reg    <= '0;
            ov_reg    <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (s_acc) begin
                mode_reg <= mode_next;
                tc_reg   <= tc_next;
                cc_reg   <= cc_next;
                ov_reg   <= ov_next;
                tail_reg <= tail_reg + FIFO_AW'(n_res);
            end
            if (m_acc) begin
                head_reg <= head_reg + 1'b1;
            end
            count_reg <= count_reg + (s_acc ? (FIFO_AW + 1)'(n_res) : '0)
                                   - (m_acc ? (FIFO_AW + 1)'(1) : '0);
        end
    end

    // result queue payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc && (n_res != 2'd0)) begin
            fifo_reg[tail_reg] <= r0;
        end
        if (s_acc && (n_res == 2'd2)) begin
            fifo_reg[tail_reg + 1'b1] <= r1;
        end
    end

    res_t head_res;
    assign head_res = fifo_reg[head_reg];

    assign m_tuser = head_res.kind;
    assign m_tlast = head_res.last;
    assign m_tdata = {1'b0, head_res.overflow, head_res.from_string,
                      head_res.char_position, head_res.token_index, head_res.char_value};

    // queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // a character is only taken with room for two results
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |-> count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH - 2))
        else $error("character accepted without queue room");

    // line end closes the line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && n_res != 2'd0 && (r0.kind == KIND_LEND || r1.kind == KIND_LEND))
            |=> mode_reg == M_DONE)
        else $error("line end did not close the line");

    // a finished line produces nothing until a new line starts
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !s_tuser && mode_reg == M_DONE) |-> n_res == 2'd0)
        else $error("result after line end");

    // a result pair always ends in a line end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && n_res == 2'd2) |-> (r1.kind == KIND_LEND && r0.kind == KIND_TEND))
        else $error("bad result pair");

endmodule
